// ===== rtl/slg_pkg.sv =====
// Shared types, constants and fixed-point helpers for the SwiGLU forward/backward unit.
`default_nettype none

package slg_pkg;

    // Pipeline geometry: four sigmoid stages followed by five gradient stages.
    localparam int NUM_STAGES           = 9;
    localparam int SIG_STAGES           = 4;
    localparam int SIGMOID_SEGMENTS_DEF = 32;

    // Sigmoid value width: unsigned Q16, 0 to 65536.
    localparam int SIG_W = 17;

    localparam logic [63:0]        Q31_ONE  = 64'd1 << 31;
    localparam int                 Q_SHIFT  = 28;
    localparam logic signed [63:0] Q28_HALF = 64'sd1 <<< (Q_SHIFT - 1);
    localparam logic signed [33:0] Q28_ONE  = 34'sd1 <<< Q_SHIFT;

    typedef enum logic {
        CMD_FORWARD  = 1'b0,
        CMD_BACKWARD = 1'b1
    } t_slg_cmd;

    typedef struct packed {
        t_slg_cmd           command;
        logic signed [15:0] gate;
        logic signed [15:0] up;
        logic signed [15:0] dout;
        logic signed [15:0] prior_gate_grad;
        logic signed [15:0] prior_up_grad;
    } t_slg_in;

    typedef struct packed {
        logic signed [15:0] primary_value;
        logic signed [15:0] secondary_value;
        logic               saturated;
    } t_slg_out;

    typedef struct packed {
        logic gate_grad_enable;
        logic up_grad_enable;
    } t_slg_cfg;

    // Per-stage load enables, driven by the valid tracking in the top level.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

    typedef struct packed {
        logic               flag;
        logic signed [15:0] value;
    } t_sat;

    // Drop 28 fraction bits, rounding to nearest with halves away from zero.
    function automatic logic signed [63:0] round_q28(input logic signed [63:0] v);
        logic signed [63:0] bias;
        bias = v[63] ? (Q28_HALF - 64'sd1) : Q28_HALF;
        return (v + bias) >>> Q_SHIFT;
    endfunction

    // Clamp to the signed 16-bit range and report whether clamping occurred.
    function automatic t_sat sat16(input logic signed [63:0] v);
        t_sat r;
        if (v > 64'sd32767) begin
            r.flag  = 1'b1;
            r.value = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r.flag  = 1'b1;
            r.value = -16'sh8000;
        end else begin
            r.flag  = 1'b0;
            r.value = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/slg_sigmoid.sv =====
// Sigmoid front end: piecewise-linear table lookup and interpolation over four stages.
`default_nettype none

module slg_sigmoid #(
    parameter int SIGMOID_SEGMENTS = slg_pkg::SIGMOID_SEGMENTS_DEF
) (
    input  wire logic                       i_clk,
    input  wire slg_pkg::t_pipe_ctl         i_ctl,
    input  wire slg_pkg::t_slg_in           i_item,
    output slg_pkg::t_slg_in                o_item,
    output logic [slg_pkg::SIG_W-1:0]       o_sig
);
    import slg_pkg::*;

    localparam int KW = $clog2(SIGMOID_SEGMENTS);
    localparam int PW = 16 + KW;

    // Node table, built at elaboration from a Q31 series for e^-|x|.
    logic [SIG_W-1:0] w_node   [SIGMOID_SEGMENTS+1];
    logic [SIG_W-1:0] w_lo_tab [SIGMOID_SEGMENTS];
    logic [SIG_W-1:0] w_dl_tab [SIGMOID_SEGMENTS];

    for (genvar k = 0; k <= SIGMOID_SEGMENTS; k++) begin : g_node
        localparam bit NEG = (16 * k < 8 * SIGMOID_SEGMENTS);
        localparam logic [63:0] AD = NEG ? 64'(8 * SIGMOID_SEGMENTS - 16 * k)
                                         : 64'(16 * k - 8 * SIGMOID_SEGMENTS);
        localparam logic [63:0] A   = (AD << 31) / 64'(SIGMOID_SEGMENTS);
        localparam logic [63:0] Y   = (A + 64'd8) >> 4;
        localparam logic [63:0] T1  = (Q31_ONE * Y) >> 31;
        localparam logic [63:0] T2  = ((T1 * Y) >> 31) / 64'd2;
        localparam logic [63:0] T3  = ((T2 * Y) >> 31) / 64'd3;
        localparam logic [63:0] T4  = ((T3 * Y) >> 31) / 64'd4;
        localparam logic [63:0] T5  = ((T4 * Y) >> 31) / 64'd5;
        localparam logic [63:0] T6  = ((T5 * Y) >> 31) / 64'd6;
        localparam logic [63:0] T7  = ((T6 * Y) >> 31) / 64'd7;
        localparam logic [63:0] T8  = ((T7 * Y) >> 31) / 64'd8;
        localparam logic [63:0] T9  = ((T8 * Y) >> 31) / 64'd9;
        localparam logic [63:0] T10 = ((T9 * Y) >> 31) / 64'd10;
        localparam logic [63:0] T11 = ((T10 * Y) >> 31) / 64'd11;
        localparam logic [63:0] T12 = ((T11 * Y) >> 31) / 64'd12;
        localparam logic [63:0] SUM = Q31_ONE - T1 + T2 - T3 + T4 - T5 + T6
                                      - T7 + T8 - T9 + T10 - T11 + T12;
        localparam logic [63:0] V1  = (SUM * SUM + (64'd1 << 30)) >> 31;
        localparam logic [63:0] V2  = (V1 * V1 + (64'd1 << 30)) >> 31;
        localparam logic [63:0] V3  = (V2 * V2 + (64'd1 << 30)) >> 31;
        localparam logic [63:0] V4  = (V3 * V3 + (64'd1 << 30)) >> 31;
        localparam logic [63:0] SP  = (64'd1 << 62) / (Q31_ONE + V4);
        localparam logic [63:0] SPS = NEG ? (Q31_ONE - SP) : SP;
        assign w_node[k] = SIG_W'((SPS + (64'd1 << 14)) >> 15);
    end

    // Per-segment base value and non-negative slope.
    for (genvar k = 0; k < SIGMOID_SEGMENTS; k++) begin : g_seg
        assign w_lo_tab[k] = w_node[k];
        assign w_dl_tab[k] = (w_node[k+1] >= w_node[k]) ? (w_node[k+1] - w_node[k])
                                                        : '0;
    end

    logic [PW-1:0]    w_pos;
    t_slg_in          r0_item, r1_item, r2_item, r3_item;
    logic [KW-1:0]    r0_k;
    logic [15:0]      r0_f, r1_f;
    logic [SIG_W-1:0] r1_lo, r1_dl, r2_lo, r3_s;
    logic [32:0]      r2_prod;

    // Offset-binary gate times segment count: upper bits pick the segment.
    assign w_pos = PW'({~i_item.gate[15], i_item.gate[14:0]}) * PW'(SIGMOID_SEGMENTS);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r0_item <= i_item;
            r0_k    <= w_pos[PW-1:16];
            r0_f    <= w_pos[15:0];
        end
        if (i_ctl.load[1]) begin
            r1_item <= r0_item;
            r1_lo   <= w_lo_tab[r0_k];
            r1_dl   <= w_dl_tab[r0_k];
            r1_f    <= r0_f;
        end
        if (i_ctl.load[2]) begin
            r2_item <= r1_item;
            r2_lo   <= r1_lo;
            r2_prod <= 33'(r1_dl) * 33'(r1_f);
        end
        if (i_ctl.load[3]) begin
            r3_item <= r2_item;
            r3_s    <= r2_lo + SIG_W'((r2_prod + 33'd32768) >> 16);
        end
    end

    assign o_item = r3_item;
    assign o_sig  = r3_s;

endmodule

`default_nettype wire

// ===== rtl/slg_grad.sv =====
// Product, derivative and accumulation stages producing the registered result beat.
`default_nettype none

module slg_grad (
    input  wire logic                   i_clk,
    input  wire slg_pkg::t_pipe_ctl     i_ctl,
    input  wire slg_pkg::t_slg_cfg      i_cfg,
    input  wire slg_pkg::t_slg_in       i_item,
    input  wire logic [slg_pkg::SIG_W-1:0] i_sig,
    output slg_pkg::t_slg_out           o_data
);
    import slg_pkg::*;

    logic signed [17:0] w_s_in, w_s4, w_oms;
    logic signed [33:0] w_inner;
    t_sat               w_gate;
    t_slg_out           n_data;

    // Stage 4: first-level products.
    t_slg_cmd           r4_cmd;
    logic signed [15:0] r4_u, r4_pg, r4_pu;
    logic [SIG_W-1:0]   r4_s;
    logic signed [33:0] r4_gs, r4_om;
    logic signed [31:0] r4_dg, r4_du;
    // Stage 5: second-level products.
    t_slg_cmd           r5_cmd;
    logic signed [15:0] r5_pg, r5_pu;
    logic signed [31:0] r5_du;
    logic signed [47:0] r5_fp, r5_upp;
    logic signed [49:0] r5_si;
    // Stage 6: rounding and the forward and up-gradient results.
    t_slg_cmd           r6_cmd;
    logic signed [15:0] r6_pg, r6_pu;
    logic signed [31:0] r6_du;
    t_sat               r6_fwd, r6_upr;
    logic signed [21:0] r6_dsilu;
    // Stage 7: gate-gradient product.
    t_slg_cmd           r7_cmd;
    logic signed [15:0] r7_pg, r7_pu;
    t_sat               r7_fwd, r7_upr;
    logic signed [53:0] r7_gp;
    // Stage 8: output register.
    t_slg_out           r8_data;

    assign w_s_in  = $signed({1'b0, i_sig});
    assign w_oms   = 18'sd65536 - w_s_in;
    assign w_s4    = $signed({1'b0, r4_s});
    assign w_inner = Q28_ONE + r4_om;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r4_cmd <= i_item.command;
            r4_u   <= i_item.up;
            r4_pg  <= i_item.prior_gate_grad;
            r4_pu  <= i_item.prior_up_grad;
            r4_s   <= i_sig;
            r4_gs  <= 34'($signed(i_item.gate)) * 34'(w_s_in);
            r4_om  <= 34'($signed(i_item.gate)) * 34'(w_oms);
            r4_dg  <= 32'($signed(i_item.dout)) * 32'($signed(i_item.gate));
            r4_du  <= 32'($signed(i_item.dout)) * 32'($signed(i_item.up));
        end
        if (i_ctl.load[5]) begin
            r5_cmd <= r4_cmd;
            r5_pg  <= r4_pg;
            r5_pu  <= r4_pu;
            r5_du  <= r4_du;
            r5_fp  <= 48'(r4_gs) * 48'(r4_u);
            r5_upp <= 48'(r4_dg) * 48'(w_s4);
            r5_si  <= 50'(w_s4) * 50'(w_inner);
        end
        if (i_ctl.load[6]) begin
            r6_cmd   <= r5_cmd;
            r6_pg    <= r5_pg;
            r6_pu    <= r5_pu;
            r6_du    <= r5_du;
            r6_fwd   <= sat16(round_q28(64'(r5_fp)));
            r6_upr   <= sat16(64'(r5_pu) + round_q28(64'(r5_upp)));
            r6_dsilu <= 22'(round_q28(64'(r5_si)));
        end
        if (i_ctl.load[7]) begin
            r7_cmd <= r6_cmd;
            r7_pg  <= r6_pg;
            r7_pu  <= r6_pu;
            r7_fwd <= r6_fwd;
            r7_upr <= r6_upr;
            r7_gp  <= 54'(r6_du) * 54'(r6_dsilu);
        end
        if (i_ctl.load[8]) begin
            r8_data <= n_data;
        end
    end

    assign w_gate = sat16(64'(r7_pg) + round_q28(64'(r7_gp)));

    // A disabled gradient passes its prior value through and cannot flag saturation.
    always_comb begin
        n_data = '0;
        case (r7_cmd)
            CMD_FORWARD: begin
                n_data.primary_value   = r7_fwd.value;
                n_data.secondary_value = '0;
                n_data.saturated       = r7_fwd.flag;
            end
            CMD_BACKWARD: begin
                n_data.primary_value   = i_cfg.gate_grad_enable ? w_gate.value : r7_pg;
                n_data.secondary_value = i_cfg.up_grad_enable ? r7_upr.value : r7_pu;
                n_data.saturated       = (i_cfg.gate_grad_enable & w_gate.flag)
                                       | (i_cfg.up_grad_enable & r7_upr.flag);
            end
            default: begin
                n_data = '0;
            end
        endcase
    end

    assign o_data = r8_data;

endmodule

`default_nettype wire

// ===== rtl/swiglu_forward_backward_unit.sv =====
// Top level of the SwiGLU forward/backward unit: register port, pipeline control, datapath.
`default_nettype none

// Usage
// Input beats arrive on i_valid/o_stall with the payload in i_data; result beats
// leave on o_valid/i_stall with the payload in o_data. A command of forward gives
// gate*sigmoid(gate)*up; a command of backward gives the updated gate and up
// gradients. One result beat is produced for every input beat, in order.
// Each beat passes through the nine register stages in order to the output register.
// Throughput is one beat per clock while the receiver does not stall: every one of
// the nine register stages holds its own item, and the longest chain is the
// gate-gradient path of three multiplier stages and a rounding stage behind the
// sigmoid table lookup and interpolation.
// When the receiver stalls, the result held in the output register stays put and
// the stages behind it keep filling any empty slots; o_stall rises only once all
// nine stages are occupied, so nothing is dropped or repeated.
// Reset clears every valid bit and sets both gradient enables. The sigmoid table is
// constant, so the unit takes beats from the first cycle after reset.
// The enables at byte addresses 0 and 4 should be written only while the unit is idle.

module swiglu_forward_backward_unit #(
    parameter int SIGMOID_SEGMENTS = slg_pkg::SIGMOID_SEGMENTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire slg_pkg::t_slg_in   i_data,
    // Output channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output slg_pkg::t_slg_out       o_data,
    // Register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import slg_pkg::*;

    localparam logic REG_GATE_GRAD_EN = 1'b0;
    localparam logic REG_UP_GRAD_EN   = 1'b1;

    // ------------------------------------------------------------------
    // Register port. Registers sit on 32-bit word boundaries, so bit 2 of the
    // address selects between them; only bit 0 of the written word is kept.
    // ------------------------------------------------------------------
    logic     r_gate_grad_en, r_up_grad_en;
    logic     w_wr;
    t_slg_cfg w_cfg;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_grad_en <= 1'b1;
            r_up_grad_en   <= 1'b1;
        end else if (w_wr) begin
            case (paddr[2])
                REG_GATE_GRAD_EN: r_gate_grad_en <= pwdata[0];
                REG_UP_GRAD_EN:   r_up_grad_en   <= pwdata[0];
                default: begin
                    r_gate_grad_en <= r_gate_grad_en;
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_GATE_GRAD_EN: prdata[0] = r_gate_grad_en;
            REG_UP_GRAD_EN:   prdata[0] = r_up_grad_en;
            default:          prdata    = '0;
        endcase
    end

    assign w_cfg.gate_grad_enable = r_gate_grad_en;
    assign w_cfg.up_grad_enable   = r_up_grad_en;

    // ------------------------------------------------------------------
    // Pipeline control. Each stage carries a valid bit alongside its data. A stage
    // loads when it is empty or when the stage after it is loading, so bubbles are
    // squeezed out even while the output register is held by a stall.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] r_valid, n_valid;
    logic [NUM_STAGES-1:0] w_load;
    t_pipe_ctl             w_ctl;

    always_comb begin
        w_load[NUM_STAGES-1] = ~r_valid[NUM_STAGES-1] | ~i_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            w_load[i] = ~r_valid[i] | w_load[i+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_load[0]) begin
            n_valid[0] = i_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (w_load[i]) begin
                n_valid[i] = r_valid[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign w_ctl.load = w_load;
    assign o_stall    = ~w_load[0];
    assign o_valid    = r_valid[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Datapath: sigmoid lookup and interpolation, then products and accumulation.
    // ------------------------------------------------------------------
    t_slg_in          w_sig_item;
    logic [SIG_W-1:0] w_sig;

    slg_sigmoid #(
        .SIGMOID_SEGMENTS(SIGMOID_SEGMENTS)
    ) u_sigmoid (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_item (i_data),
        .o_item (w_sig_item),
        .o_sig  (w_sig)
    );

    slg_grad u_grad (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_cfg  (w_cfg),
        .i_item (w_sig_item),
        .i_sig  (w_sig),
        .o_data (o_data)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The unit only pushes back once every stage holds an item.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_valid))
        else $error("input stalled while a pipeline slot was free");

    // An accepted beat always occupies the first stage on the next cycle.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_valid[0])
        else $error("accepted beat did not enter the pipeline");

    // The saturation flag implies at least one output sits on a range limit.
    a_sat_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.saturated) |->
            (o_data.primary_value == 16'sh7FFF || o_data.primary_value == -16'sh8000 ||
             o_data.secondary_value == 16'sh7FFF || o_data.secondary_value == -16'sh8000))
        else $error("saturation flagged on an unclamped result");

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid directly after reset");

endmodule

`default_nettype wire
